@@ design/ssf_pkg.sv @@
// Shared types and constants for the shortest-seek-first scheduler.
package ssf_pkg;

    localparam int unsigned FIELD_TRACK_BITS = 16;
    localparam int unsigned SUM_BITS         = 23;
    localparam int unsigned COUNT_BITS       = 8;
    localparam logic [SUM_BITS-1:0]   SUM_MAX   = 23'h7F_FFFF;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [FIELD_TRACK_BITS-1:0] request_track;
        logic                        last_request;
    } t_in_item;

    typedef struct packed {
        logic [SUM_BITS-1:0]   total_movement;
        logic [COUNT_BITS-1:0] served_count;
        logic                  overflowed;
    } t_out_item;

    typedef enum logic {
        S_LOAD,
        S_SCAN
    } t_state;

    // Broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic load;
        logic mark;
        logic clear;
    } t_cell_ctl;

endpackage

@@ design/ssf_cell.sv @@
// One request cell: holds a track, its flags, and one stage of the nearest-request chain.
module ssf_cell #(
    parameter int unsigned TRACK_BITS = 16,
    parameter int unsigned IDX_BITS   = 7,
    parameter int unsigned INDEX      = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ssf_pkg::t_cell_ctl    i_ctl,
    input  logic [IDX_BITS-1:0]   i_wr_idx,
    input  logic [TRACK_BITS-1:0] i_wr_track,
    input  logic [IDX_BITS-1:0]   i_pick_idx,
    input  logic [TRACK_BITS-1:0] i_head,
    input  logic                  i_found,
    input  logic [TRACK_BITS-1:0] i_dist,
    input  logic [IDX_BITS-1:0]   i_idx,
    input  logic [TRACK_BITS-1:0] i_track,
    output logic                  o_found,
    output logic [TRACK_BITS-1:0] o_dist,
    output logic [IDX_BITS-1:0]   o_idx,
    output logic [TRACK_BITS-1:0] o_track
);
    import ssf_pkg::*;

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(INDEX);

    logic [TRACK_BITS-1:0] r_track;
    logic                  r_stored;
    logic                  r_served;
    logic                  r_found;
    logic [TRACK_BITS-1:0] r_dist;
    logic [IDX_BITS-1:0]   r_idx;
    logic [TRACK_BITS-1:0] r_ctrack;

    logic [TRACK_BITS-1:0] w_d;
    logic                  w_take;

    always_comb begin
        w_d    = (r_track >= i_head) ? (r_track - i_head) : (i_head - r_track);
        // Strictly closer only, so a tie stays with the earlier cell
        w_take = r_stored && !r_served && (!i_found || (w_d < i_dist));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored <= 1'b0;
            r_served <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_stored <= 1'b0;
                r_served <= 1'b0;
            end else if (i_ctl.load && (i_wr_idx == MY_IDX)) begin
                r_stored <= 1'b1;
                r_served <= 1'b0;
            end else if (i_ctl.mark && (i_pick_idx == MY_IDX)) begin
                r_served <= 1'b1;
            end
            r_found <= w_take || i_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_wr_idx == MY_IDX)) begin
            r_track <= i_wr_track;
        end
        if (w_take) begin
            r_dist   <= w_d;
            r_idx    <= MY_IDX;
            r_ctrack <= r_track;
        end else begin
            r_dist   <= i_dist;
            r_idx    <= i_idx;
            r_ctrack <= i_track;
        end
    end

    assign o_found = r_found;
    assign o_dist  = r_dist;
    assign o_idx   = r_idx;
    assign o_track = r_ctrack;

endmodule

@@ design/shortest_seek_first_scheduler_top.sv @@
// Shortest-seek-first scheduler: request cells, selection sequencer and result register.
// Each request taken while loading goes to the next free cell; once all cells are full, it is dropped and flagged.
// After the last request, one selection is made per stored request, each once the nearest-request chain
// has settled through every cell; the result is registered with the last selection.
// The result register lets loading of the next batch start while a result waits.
// Reset (synchronous, active low) empties all cells and zeroes the head, sum and start track.
module shortest_seek_first_scheduler_top #(
    parameter int unsigned MAX_REQUESTS = 128,
    parameter int unsigned TRACK_BITS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ssf_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ssf_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata
);
    import ssf_pkg::*;

    localparam int unsigned IDX_BITS = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int unsigned CNT_BITS = $clog2(MAX_REQUESTS + 1);
    localparam int unsigned TMR_BITS = $clog2(MAX_REQUESTS + 1);
    localparam int unsigned SUM_W    = (TRACK_BITS + 1 > SUM_BITS + 1) ?
                                       TRACK_BITS + 1 : SUM_BITS + 1;
    localparam logic [CNT_BITS-1:0] CNT_FULL  = CNT_BITS'(MAX_REQUESTS);
    localparam logic [TMR_BITS-1:0] TMR_SETTLE = TMR_BITS'(MAX_REQUESTS);

    t_state                r_state, n_state;
    logic [15:0]           r_start;
    logic [CNT_BITS-1:0]   r_count;
    logic [CNT_BITS-1:0]   r_left;
    logic [TMR_BITS-1:0]   r_timer;
    logic                  r_ovf;
    logic [TRACK_BITS-1:0] r_head;
    logic [SUM_BITS-1:0]   r_sum;
    t_out_item             r_out;
    logic                  r_out_valid;

    t_cell_ctl             w_ctl;
    logic                  w_accept;
    logic                  w_select;
    logic                  w_finish;
    logic [31:0]           w_req32;
    logic [31:0]           w_start32;
    logic [TRACK_BITS-1:0] w_req;
    logic [TRACK_BITS-1:0] w_start;
    logic [CNT_BITS-1:0]   w_count_after;
    logic [SUM_W-1:0]      w_sum_wide;
    logic [SUM_BITS-1:0]   n_sum;
    logic [31:0]           w_count32;
    logic [COUNT_BITS-1:0] w_served;

    logic                  w_c_found [MAX_REQUESTS:0];
    logic [TRACK_BITS-1:0] w_c_dist  [MAX_REQUESTS:0];
    logic [IDX_BITS-1:0]   w_c_idx   [MAX_REQUESTS:0];
    logic [TRACK_BITS-1:0] w_c_track [MAX_REQUESTS:0];

    assign w_req32   = {16'd0, i_in_data.request_track};
    assign w_start32 = {16'd0, r_start};
    assign w_req     = w_req32[TRACK_BITS-1:0];
    assign w_start   = w_start32[TRACK_BITS-1:0];

    assign w_c_found[0] = 1'b0;
    assign w_c_dist[0]  = '0;
    assign w_c_idx[0]   = '0;
    assign w_c_track[0] = '0;

    for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
        ssf_cell #(
            .TRACK_BITS (TRACK_BITS),
            .IDX_BITS   (IDX_BITS),
            .INDEX      (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_wr_idx   (r_count[IDX_BITS-1:0]),
            .i_wr_track (w_req),
            .i_pick_idx (w_c_idx[MAX_REQUESTS]),
            .i_head     (r_head),
            .i_found    (w_c_found[g]),
            .i_dist     (w_c_dist[g]),
            .i_idx      (w_c_idx[g]),
            .i_track    (w_c_track[g]),
            .o_found    (w_c_found[g+1]),
            .o_dist     (w_c_dist[g+1]),
            .o_idx      (w_c_idx[g+1]),
            .o_track    (w_c_track[g+1])
        );
    end

    assign o_in_stall = (r_state != S_LOAD);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        w_count_after = r_count + CNT_BITS'(w_ctl.load);
        w_sum_wide    = SUM_W'(r_sum) + SUM_W'(w_c_dist[MAX_REQUESTS]);
        n_sum         = (w_sum_wide > SUM_W'(SUM_MAX)) ? SUM_MAX : w_sum_wide[SUM_BITS-1:0];
        w_count32     = 32'(r_count);
        w_served      = (w_count32 > 32'(COUNT_MAX)) ? COUNT_MAX : w_count32[COUNT_BITS-1:0];
    end

    always_comb begin
        n_state  = r_state;
        w_ctl    = '0;
        w_select = 1'b0;
        w_finish = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                w_ctl.load = w_accept && (r_count < CNT_FULL);
                if (w_accept && i_in_data.last_request) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_timer == TMR_SETTLE) begin
                    if (r_left != CNT_BITS'(1)) begin
                        w_select = 1'b1;
                    end else if (!r_out_valid || !i_out_stall) begin
                        // Last pick: only when the result slot can take it
                        w_select = 1'b1;
                        w_finish = 1'b1;
                        n_state  = S_LOAD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
        w_ctl.mark  = w_select;
        w_ctl.clear = w_finish;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_start     <= '0;
            r_count     <= '0;
            r_left      <= '0;
            r_timer     <= '0;
            r_ovf       <= 1'b0;
            r_head      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_start <= i_cfg_wdata;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_LOAD && w_accept) begin
                r_count <= w_count_after;
                if (!w_ctl.load) begin
                    r_ovf <= 1'b1;
                end
                if (i_in_data.last_request) begin
                    r_head  <= w_start;
                    r_sum   <= '0;
                    r_left  <= w_count_after;
                    r_timer <= '0;
                end
            end
            if (r_state == S_SCAN) begin
                if (r_timer != TMR_SETTLE) begin
                    r_timer <= r_timer + TMR_BITS'(1);
                end
                if (w_select) begin
                    r_sum   <= n_sum;
                    r_head  <= w_c_track[MAX_REQUESTS];
                    r_left  <= r_left - CNT_BITS'(1);
                    r_timer <= '0;
                end
                if (w_finish) begin
                    r_count     <= '0;
                    r_ovf       <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out.total_movement <= n_sum;
            r_out.served_count   <= w_served;
            r_out.overflowed     <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_left != '0))
        else $error("scan running with no requests left");

    a_pick_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_select |-> w_c_found[MAX_REQUESTS])
        else $error("selection made with no unserved request in the chain");

    a_batch_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> (r_count == '0) && !r_ovf && o_out_valid)
        else $error("batch state not cleared when result issued");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("stored count beyond capacity");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the shortest-seek-first scheduler: directed and random batches vs an SSTF predictor.
`timescale 1ns / 1ps

module testbench;
    import ssf_pkg::*;

    localparam int unsigned BATCH_CAP   = 128;
    localparam int unsigned TRACKS      = 16;
    localparam int unsigned HOLD_CYCLES = 4000;
    localparam int unsigned SETTLE      = BATCH_CAP + 10;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    // Stimulus still to be offered, and results still to come back
    t_in_item    request_feed[$];
    t_out_item   pending_totals[$];

    // Predictor state: the batch being loaded and the configured start track
    logic [15:0] track_store[BATCH_CAP];
    int unsigned stored;
    bit          dropped;
    logic [15:0] head_start;

    int unsigned error_count;
    int unsigned feed_gap;
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_armed;
    bit          no_idle;
    logic [15:0] prev_track;
    t_out_item   want;

    shortest_seek_first_scheduler_top #(
        .MAX_REQUESTS(BATCH_CAP),
        .TRACK_BITS  (TRACKS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    // Serve the closest unserved request each time; ties go to the earliest loaded
    function automatic t_out_item seek_total_for_batch();
        bit          served[BATCH_CAP];
        logic [15:0] head;
        int unsigned sum;
        int unsigned best;
        int unsigned seek;
        int          pick;
        int          k;
        int          i;
        t_out_item   res;
        head = head_start;
        sum  = 0;
        for (i = 0; i < BATCH_CAP; i++) served[i] = 1'b0;
        for (k = 0; k < stored; k++) begin
            pick = -1;
            best = 0;
            for (i = 0; i < stored; i++) begin
                if (!served[i]) begin
                    seek = 32'((track_store[i] >= head) ? track_store[i] - head
                                                        : head - track_store[i]);
                    if (pick < 0 || seek < best) begin
                        best = seek;
                        pick = i;
                    end
                end
            end
            sum = sum + best;
            if (sum > SUM_MAX) sum = 32'(SUM_MAX);
            head = track_store[pick];
            served[pick] = 1'b1;
        end
        res.total_movement = sum[SUM_BITS-1:0];
        res.served_count   = (stored > COUNT_MAX) ? COUNT_MAX : stored[COUNT_BITS-1:0];
        res.overflowed     = dropped;
        return res;
    endfunction

    task automatic load_request(input t_in_item it);
        if (stored < BATCH_CAP) begin
            track_store[stored] = it.request_track;
            stored++;
        end else begin
            dropped = 1'b1;
        end
        if (it.last_request) begin
            pending_totals.push_back(seek_total_for_batch());
            stored  = 0;
            dropped = 1'b0;
        end
    endtask

    // Driver: offer the next queued transaction, holding it until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            feed_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) load_request(i_in_data);
            if (!i_in_valid || !o_in_stall) begin
                if (feed_gap != 0) begin
                    feed_gap--;
                    i_in_valid <= 1'b0;
                end else if (request_feed.size() != 0) begin
                    i_in_data  <= request_feed.pop_front();
                    i_in_valid <= 1'b1;
                    feed_gap = no_idle ? 0 : pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall, including the one long hold-off that backs the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_armed) begin
            hold_armed = 1'b0;
            hold_left  = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            stall_left = no_idle ? 0 : pick_gap();
            i_out_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_totals.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d", $time,
                         o_out_data.total_movement, o_out_data.served_count,
                         o_out_data.overflowed);
                error_count++;
            end else begin
                want = pending_totals.pop_front();
                if (o_out_data.total_movement !== want.total_movement) begin
                    $display("%0t: total_movement expected %0d actual %0d", $time,
                             want.total_movement, o_out_data.total_movement);
                    error_count++;
                end
                if (o_out_data.served_count !== want.served_count) begin
                    $display("%0t: served_count expected %0d actual %0d", $time,
                             want.served_count, o_out_data.served_count);
                    error_count++;
                end
                if (o_out_data.overflowed !== want.overflowed) begin
                    $display("%0t: overflowed expected %0d actual %0d", $time,
                             want.overflowed, o_out_data.overflowed);
                    error_count++;
                end
            end
        end
    end

    task automatic push_request(input logic [15:0] track, input bit last);
        t_in_item it;
        it.request_track = track;
        it.last_request  = last;
        request_feed.push_back(it);
        prev_track = track;
    endtask

    // Extremes, low tracks, repeats of the previous track (ties), tracks near the start track and plain random
    function automatic logic [15:0] random_track();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 15));
            3: return prev_track;
            4: return head_start ^ 16'($urandom_range(0, 63));
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic queue_batch(input int unsigned len);
        int unsigned n;
        for (n = 1; n <= len; n++) push_request(random_track(), n == len);
    endtask

    task automatic wait_for_drain();
        while (request_feed.size() != 0 || i_in_valid || pending_totals.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_start_track(input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        head_start = value;
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned phase;
        int unsigned phase_items;
        int unsigned len;
        logic [15:0] setting;
        stored      = 0;
        dropped     = 1'b0;
        head_start  = '0;
        error_count = 0;
        hold_armed  = 1'b0;
        no_idle     = 1'b0;
        prev_track  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, alternating bits, and a tie that changes the total
        write_start_track(16'h0000);
        push_request(16'h0000, 1'b1);
        push_request(16'hFFFF, 1'b1);
        push_request(16'hFFFF, 1'b0);
        push_request(16'h0000, 1'b0);
        push_request(16'h8000, 1'b1);
        push_request(16'hAAAA, 1'b0);
        push_request(16'h5555, 1'b1);
        wait_for_drain();
        write_start_track(16'd10);
        push_request(16'd20, 1'b0);
        push_request(16'd0, 1'b0);
        push_request(16'd25, 1'b1);
        push_request(16'd10, 1'b1);
        wait_for_drain();
        write_start_track(16'hFFFF);
        push_request(16'h0000, 1'b1);
        push_request(16'hFFFF, 1'b0);
        push_request(16'hFFFF, 1'b1);
        wait_for_drain();

        // Random phases, each under its own start track
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: setting = 16'h8000;
                1: setting = 16'h0000;
                2: setting = 16'hFFFF;
                5: setting = 16'h0001;
                default: setting = 16'($urandom());
            endcase
            write_start_track(setting);
            no_idle     = (phase == 4);
            hold_armed  = (phase == 0);
            phase_items = 0;
            case (phase)
                1: begin queue_batch(BATCH_CAP);      phase_items = BATCH_CAP;      end
                2: begin queue_batch(BATCH_CAP + 1);  phase_items = BATCH_CAP + 1;  end
                3: begin queue_batch(BATCH_CAP + 12); phase_items = BATCH_CAP + 12; end
                default: ;
            endcase
            while (phase_items < 120 + ((phase == 0 || phase >= 4) ? 120 : 0)) begin
                len = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 8)
                                                  : $urandom_range(9, 40);
                queue_batch(len);
                phase_items += len;
            end
            wait_for_drain();
        end

        if (error_count == 0) begin
            $display("shortest_seek_first_scheduler_top regression: pass");
        end else begin
            $display("shortest_seek_first_scheduler_top regression: fail");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("shortest_seek_first_scheduler_top regression: fail");
        $finish;
    end

endmodule
